// ===== rtl/core/pva_pkg.sv =====
// Shared types, constants and helpers for the polyphonic voice allocator.
// Used by pva_voice_cell, pva_note_map and polyphonic_voice_allocator.
// No dependencies.
package pva_pkg;

    localparam int MAX_VOICES = 16;
    localparam int NOTE_SLOTS = 128;
    localparam int VOICE_W    = $clog2(MAX_VOICES);
    localparam int CNT_W      = $clog2(MAX_VOICES + 1);
    localparam int NOTE_W     = 8;
    localparam int MAP_W      = $clog2(NOTE_SLOTS);
    localparam int TIME_W     = 32;

    localparam logic [CNT_W-1:0]  VOICE_NONE = CNT_W'(MAX_VOICES);
    localparam logic [NOTE_W-1:0] NOTE_NONE  = NOTE_W'(NOTE_SLOTS);

    localparam logic [1:0] MODE_CHOOSE     = 2'd0;
    localparam logic [1:0] MODE_ACTIVATE   = 2'd1;
    localparam logic [1:0] MODE_DEACTIVATE = 2'd2;
    localparam logic [1:0] MODE_QUERY      = 2'd3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_VOICE_COUNT = 1'b0;

    // Input beat.
    typedef struct packed {
        logic [1:0]        mode;
        logic [3:0]        voice;
        logic [NOTE_W-1:0] note;
        logic [TIME_W-1:0] now_ms;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic [4:0]        chosen_voice;
        logic [NOTE_W-1:0] stolen_note;
        logic [4:0]        voice_of_note;
        logic [NOTE_W-1:0] note_of_voice;
        logic [4:0]        oldest_voice;
        logic [4:0]        active_total;
    } result_t;

    // Broadcast write to the voice cells.
    typedef struct packed {
        logic               en;
        logic               set;
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  note;
        logic [TIME_W-1:0]  start;
    } voice_wr_t;

    // Write to the note-to-voice map.
    typedef struct packed {
        logic               en;
        logic               set;
        logic [MAP_W-1:0]   note;
        logic [VOICE_W-1:0] voice;
    } map_wr_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               hi_found;
        logic [VOICE_W-1:0] hi_idx;
        logic               lo_found;
        logic [VOICE_W-1:0] lo_idx;
        logic               has_best;
        logic [VOICE_W-1:0] best_idx;
        logic [TIME_W-1:0]  best_start;
        logic [NOTE_W-1:0]  best_note;
        logic [NOTE_W-1:0]  qnote;
    } carry_t;

    // Voices in use: zero acts as one, anything above the pool as the pool size.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [4:0] raw);
        logic [CNT_W-1:0] res;
        if (raw == 5'd0)
        begin
            res = CNT_W'(1);
        end
        else if (32'(raw) > MAX_VOICES)
        begin
            res = CNT_W'(MAX_VOICES);
        end
        else
        begin
            res = CNT_W'(raw);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/pva_voice_cell.sv =====
// One voice cell: holds the voice's active flag, note and start time, and
// folds its state into the search token passed down the row.
// Depends on pva_pkg.
module pva_voice_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pva_pkg::VOICE_W-1:0]   cell_idx,
    input  pva_pkg::voice_wr_t            wr,
    input  logic [pva_pkg::CNT_W-1:0]     live_n,
    input  logic [pva_pkg::VOICE_W-1:0]   rr_start,
    input  logic [pva_pkg::VOICE_W-1:0]   qvoice,
    input  pva_pkg::carry_t               carry_in,
    output pva_pkg::carry_t               carry_out
);
    import pva_pkg::*;

    logic              busy_reg,  busy_next;
    logic [NOTE_W-1:0] note_reg,  note_next;
    logic [TIME_W-1:0] start_reg, start_next;
    carry_t            carry_reg, carry_next;
    logic              in_range;
    logic              hit;

    assign hit      = wr.en && (wr.voice == cell_idx);
    assign in_range = {1'b0, cell_idx} < live_n;

    always_comb
    begin
        busy_next  = busy_reg;
        note_next  = note_reg;
        start_next = start_reg;
        if (hit)
        begin
            busy_next  = wr.set;
            note_next  = wr.set ? wr.note : NOTE_NONE;
            start_next = wr.set ? wr.start : '0;
        end
    end

    // Free voices at or after the round-robin start go to the high slot, the
    // ones before it to the low slot; the first of each wins.
    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.valid && in_range)
        begin
            if (!busy_reg)
            begin
                if (cell_idx >= rr_start)
                begin
                    if (!carry_in.hi_found)
                    begin
                        carry_next.hi_found = 1'b1;
                        carry_next.hi_idx   = cell_idx;
                    end
                end
                else if (!carry_in.lo_found)
                begin
                    carry_next.lo_found = 1'b1;
                    carry_next.lo_idx   = cell_idx;
                end
            end
            if (!carry_in.has_best || (start_reg < carry_in.best_start))
            begin
                carry_next.has_best   = 1'b1;
                carry_next.best_idx   = cell_idx;
                carry_next.best_start = start_reg;
                carry_next.best_note  = note_reg;
            end
        end
        if (carry_in.valid && (cell_idx == qvoice))
        begin
            carry_next.qnote = note_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            note_reg  <= NOTE_NONE;
            start_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            note_reg  <= note_next;
            start_reg <= start_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

// ===== rtl/core/pva_note_map.sv =====
// Note-to-voice map: a 128-entry memory with one valid bit per note.
// An entry without its valid bit reads as no voice. Depends on pva_pkg.
module pva_note_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pva_pkg::map_wr_t            wr,
    input  logic [pva_pkg::MAP_W-1:0]   rd_note,
    output logic [pva_pkg::CNT_W-1:0]   rd_owner
);
    import pva_pkg::*;

    logic [VOICE_W-1:0]    mem [NOTE_SLOTS];
    logic [NOTE_SLOTS-1:0] valid_reg;
    logic [VOICE_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.set)
        begin
            mem[wr.note] <= wr.voice;
        end
        rd_data_reg <= mem[rd_note];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.note] <= wr.set;
            end
            rd_valid_reg <= valid_reg[rd_note];
        end
    end

    assign rd_owner = rd_valid_reg ? {1'b0, rd_data_reg} : VOICE_NONE;

endmodule

// ===== rtl/core/polyphonic_voice_allocator.sv =====
// Top level of the polyphonic voice allocator: control sequencer, register
// port, the row of voice cells and the note-to-voice map.
// Depends on pva_pkg, pva_voice_cell and pva_note_map.
//
//   channel   direction  handshake                      payload
//   command   in         start high while busy low      cmd    (cmd_t)
//   result    out        done high for one cycle        result (result_t)
//   config    in/out     APB write: psel,penable,pwrite paddr, pwdata, prdata
//
// After the acceptance edge the update cycle applies the update to the voice
// cells and the note map, the search token enters cell 0 in the next cycle and
// passes through the register of each of the MAX_VOICES cells down the row,
// and the result register then captures the result as the done strobe rises.
// The result beat is taken at the following edge, where a new command may
// also be accepted.
// busy is high from the acceptance edge until the edge that registers the
// result, so a new command can be taken in the cycle the result is shown.
// The receiver cannot stall: the result stays on its ports until replaced.
// After reset all voices are free, the map is empty, and voice_count is 16.
module polyphonic_voice_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pva_pkg::cmd_t    cmd,
    output logic             done,
    output pva_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pva_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPD    = 2'd1;
    localparam logic [1:0] ST_LAUNCH = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    logic [1:0]         state_reg, state_next;
    cmd_t               cmd_reg;
    logic [4:0]         voice_count_reg;
    logic [CNT_W-1:0]   busy_total_reg, busy_total_next;
    logic [VOICE_W-1:0] last_assigned_reg;
    result_t            result_reg, result_next;
    logic               done_reg;

    logic [CNT_W-1:0]   live_n;
    logic [VOICE_W-1:0] rr_start;
    logic               accept;
    logic               cfg_wr;
    logic               voice_ok;
    logic               note_ok;
    logic [NOTE_W-1:0]  note_clean;
    logic [CNT_W-1:0]   map_owner;
    logic               finish;

    voice_wr_t          voice_wr;
    map_wr_t            map_wr;
    carry_t             chain [MAX_VOICES+1];

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_VOICE_COUNT);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_VOICE_COUNT) ? {27'b0, voice_count_reg} : 32'b0;

    assign live_n   = clamp_count(voice_count_reg);
    assign voice_ok = {1'b0, cmd_reg.voice} < live_n;
    assign note_ok  = !cmd_reg.note[NOTE_W-1];
    assign note_clean = note_ok ? cmd_reg.note : NOTE_NONE;

    // The round-robin search starts at the voice after the last one
    // assigned, wrapping at the number of voices in use.
    assign rr_start = ({1'b0, last_assigned_reg} + 1'b1 == live_n) ? '0
                    : last_assigned_reg + 1'b1;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign finish = (state_reg == ST_WAIT) && chain[MAX_VOICES].valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:    state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // ------------------------------------------------------------------
    // Update of one voice during the update cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        voice_wr.en    = (state_reg == ST_UPD) && voice_ok &&
                         ((cmd_reg.mode == MODE_ACTIVATE) ||
                          (cmd_reg.mode == MODE_DEACTIVATE));
        voice_wr.set   = (cmd_reg.mode == MODE_ACTIVATE);
        voice_wr.voice = cmd_reg.voice;
        voice_wr.note  = note_clean;
        voice_wr.start = cmd_reg.now_ms;

        // Deactivate clears the map entry of the note it was given, which
        // need not be the note the voice was playing.
        map_wr.en      = voice_wr.en && note_ok;
        map_wr.set     = voice_wr.set;
        map_wr.note    = cmd_reg.note[MAP_W-1:0];
        map_wr.voice   = cmd_reg.voice;
    end

    always_comb
    begin
        busy_total_next = busy_total_reg;
        if (voice_wr.en)
        begin
            if (voice_wr.set)
            begin
                if (busy_total_reg < live_n)
                begin
                    busy_total_next = busy_total_reg + 1'b1;
                end
            end
            else if (busy_total_reg != '0)
            begin
                busy_total_next = busy_total_reg - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Row of voice cells; the token enters cell 0 in the launch cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = (state_reg == ST_LAUNCH);
        chain[0].qnote = NOTE_NONE;
    end

    for (genvar i = 0; i < MAX_VOICES; i++)
    begin : g_cell
        pva_voice_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (VOICE_W'(i)),
            .wr        (voice_wr),
            .live_n    (live_n),
            .rr_start  (rr_start),
            .qvoice    (cmd_reg.voice),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1])
        );
    end

    pva_note_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (map_wr),
        .rd_note  (cmd_reg.note[MAP_W-1:0]),
        .rd_owner (map_owner)
    );

    // ------------------------------------------------------------------
    // Result assembly from the token leaving the last cell
    // ------------------------------------------------------------------
    always_comb
    begin
        result_next.chosen_voice  = VOICE_NONE;
        result_next.stolen_note   = NOTE_NONE;
        if (cmd_reg.mode == MODE_CHOOSE)
        begin
            if (chain[MAX_VOICES].hi_found)
            begin
                result_next.chosen_voice = {1'b0, chain[MAX_VOICES].hi_idx};
            end
            else if (chain[MAX_VOICES].lo_found)
            begin
                result_next.chosen_voice = {1'b0, chain[MAX_VOICES].lo_idx};
            end
            else
            begin
                // Every voice in use is active: steal the oldest one.
                result_next.chosen_voice = {1'b0, chain[MAX_VOICES].best_idx};
                result_next.stolen_note  = chain[MAX_VOICES].best_note;
            end
        end
        result_next.voice_of_note = note_ok ? map_owner : VOICE_NONE;
        result_next.note_of_voice = voice_ok ? chain[MAX_VOICES].qnote : NOTE_NONE;
        result_next.oldest_voice  = {1'b0, chain[MAX_VOICES].best_idx};
        result_next.active_total  = busy_total_reg;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            voice_count_reg   <= 5'(MAX_VOICES);
            busy_total_reg    <= '0;
            last_assigned_reg <= VOICE_W'(MAX_VOICES - 1);
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_total_reg <= busy_total_next;
            done_reg       <= finish;
            if (cfg_wr)
            begin
                voice_count_reg   <= pwdata[4:0];
                last_assigned_reg <= VOICE_W'(clamp_count(pwdata[4:0]) - 1'b1);
            end
            else if (voice_wr.en && voice_wr.set)
            begin
                last_assigned_reg <= cmd_reg.voice;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPD))
        else $error("accepted beat did not enter the update cycle");

    a_token_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        chain[MAX_VOICES].valid |-> (state_reg == ST_WAIT))
        else $error("search token left the row outside the wait state");

    a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, last_assigned_reg} < live_n))
        else $error("last assigned voice outside the voices in use");

endmodule

// ===== tb/pva_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the polyphonic voice allocator: watches the command, result and
// register channels, keeps its own copy of the voice pool and checks every result.
// Depends on pva_pkg for the beat types, mode codes and pool sizes.
module pva_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  pva_pkg::cmd_t    cmd,
    input  logic             done,
    input  pva_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               mismatches,
    output int               outstanding,
    output int               beats_checked,
    output int               steals
);
    import pva_pkg::*;

    typedef struct {
        cmd_t    c;
        result_t r;
    } awaited_t;

    awaited_t          awaited_results[$];
    awaited_t          head;
    bit                stole;

    // Shadow of the voice pool.
    logic              on_flag[MAX_VOICES];
    logic [NOTE_W-1:0] held_note[MAX_VOICES];
    logic [TIME_W-1:0] begun_ms[MAX_VOICES];
    logic [4:0]        owner_of[NOTE_SLOTS];
    logic [4:0]        live_total;
    logic [3:0]        last_given;
    logic [4:0]        count_reg;

    function automatic int pool_size();
        int n;
        n = int'(count_reg);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > MAX_VOICES)
        begin
            n = MAX_VOICES;
        end
        return n;
    endfunction

    // Earliest start time among the voices in use, lowest index on ties.
    function automatic int earliest_voice(int n);
        int best;
        best = 0;
        for (int v = 1; v < n; v++)
        begin
            if (begun_ms[v] < begun_ms[best])
            begin
                best = v;
            end
        end
        return best;
    endfunction

    function automatic result_t allocator_outcome(cmd_t c, output bit was_steal);
        int      n;
        int      v;
        bit      voice_ok;
        bit      note_ok;
        bit      found;
        result_t r;
        n         = pool_size();
        voice_ok  = int'(c.voice) < n;
        note_ok   = int'(c.note) < NOTE_SLOTS;
        found     = 1'b0;
        was_steal = 1'b0;
        r.chosen_voice = VOICE_NONE;
        r.stolen_note  = NOTE_NONE;
        if (c.mode == MODE_CHOOSE)
        begin
            // Round-robin from the voice after the last one handed out.
            v = (int'(last_given) + 1) % n;
            for (int k = 0; k < n; k++)
            begin
                if (!found && !on_flag[v])
                begin
                    r.chosen_voice = 5'(v);
                    found          = 1'b1;
                end
                v = (v + 1) % n;
            end
            if (!found)
            begin
                v              = earliest_voice(n);
                r.chosen_voice = 5'(v);
                r.stolen_note  = held_note[v];
                was_steal      = 1'b1;
            end
        end
        else if (c.mode == MODE_ACTIVATE && voice_ok)
        begin
            if (int'(live_total) < n)
            begin
                live_total++;
            end
            held_note[c.voice] = note_ok ? c.note : NOTE_NONE;
            on_flag[c.voice]   = 1'b1;
            begun_ms[c.voice]  = c.now_ms;
            if (note_ok)
            begin
                owner_of[c.note[6:0]] = 5'(c.voice);
            end
            last_given = c.voice;
        end
        else if (c.mode == MODE_DEACTIVATE && voice_ok)
        begin
            if (live_total != 5'd0)
            begin
                live_total--;
            end
            held_note[c.voice] = NOTE_NONE;
            on_flag[c.voice]   = 1'b0;
            begun_ms[c.voice]  = '0;
            // The map entry of the given note is cleared, not that of the stored one.
            if (note_ok)
            begin
                owner_of[c.note[6:0]] = VOICE_NONE;
            end
        end
        r.voice_of_note = note_ok ? owner_of[c.note[6:0]] : VOICE_NONE;
        r.note_of_voice = voice_ok ? held_note[c.voice] : NOTE_NONE;
        r.oldest_voice  = 5'(earliest_voice(n));
        r.active_total  = live_total;
        return r;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("chosen=%0d stolen=%0d owner=%0d held=%0d oldest=%0d active=%0d",
                         r.chosen_voice, r.stolen_note, r.voice_of_note, r.note_of_voice,
                         r.oldest_voice, r.active_total);
    endfunction

    task automatic flag(string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[pva_checker] %s", msg);
        end
    endtask

    task automatic clear_model();
        for (int v = 0; v < MAX_VOICES; v++)
        begin
            on_flag[v]   = 1'b0;
            held_note[v] = NOTE_NONE;
            begun_ms[v]  = '0;
        end
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            owner_of[i] = VOICE_NONE;
        end
        live_total = '0;
        count_reg  = 5'(MAX_VOICES);
        last_given = 4'(MAX_VOICES - 1);
        awaited_results.delete();
        mismatches    = 0;
        outstanding   = 0;
        beats_checked = 0;
        steals        = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
        end
        else
        begin
            if (done)
            begin
                beats_checked++;
                if (awaited_results.size() == 0)
                begin
                    flag($sformatf("result beat with no command outstanding: %s", show(result)));
                end
                else
                begin
                    head = awaited_results.pop_front();
                    if (head.r !== result)
                    begin
                        flag($sformatf("mode %0d voice %0d note %0d t %0d: expected %s, got %s",
                                       head.c.mode, head.c.voice, head.c.note, head.c.now_ms,
                                       show(head.r), show(result)));
                    end
                end
            end
            if (psel && penable && pwrite && pready && (paddr[2] == REG_VOICE_COUNT))
            begin
                count_reg  = pwdata[4:0];
                last_given = 4'(pool_size() - 1);
            end
            if (start && !busy)
            begin
                awaited_results.push_back('{c: cmd, r: allocator_outcome(cmd, stole)});
                if (stole)
                begin
                    steals++;
                end
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the voice allocator testbench: clock, reset, command and register stimulus.
// Depends on pva_pkg, polyphonic_voice_allocator and pva_checker.
module tb;
    import pva_pkg::*;

    // The limit leaves a wide margin over the slowest correct run.
    localparam int         CYCLE_LIMIT      = 400000;
    // This pause covers one result with room to spare.
    localparam int         SETTLE_CYCLES    = 25;
    localparam int         HALF_PHASE_BEATS = 135;
    localparam logic [2:0] VOICE_COUNT_ADDR = {REG_VOICE_COUNT, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    int          beats_checked;
    int          steals;

    int          cycle_count = 0;
    int          idle_pct;
    int          beats_sent;
    int          settings_used;
    int          pool_now;
    logic [31:0] clock_ms;
    // Note each voice is sounding as far as the stimulus knows; -1 when silent.
    int          sounding[MAX_VOICES];

    always #1 clk = ~clk;

    polyphonic_voice_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pva_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .beats_checked (beats_checked),
        .steals        (steals)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     CYCLE_LIMIT, outstanding);
            $display("[polyphonic_voice_allocator] ERROR");
            $finish;
        end
    end

    function automatic cmd_t beat_of(logic [1:0] m, int v, int nt, logic [31:0] t);
        cmd_t c;
        c.mode   = m;
        c.voice  = 4'(v);
        c.note   = 8'(nt);
        c.now_ms = t;
        return c;
    endfunction

    // Offers one command beat. Called and returning at a falling edge; start is
    // left high so that a back-to-back beat never lowers and raises it in one step.
    // Before the beat the sender may sit idle, each cycle with chance idle_pct.
    task automatic issue(cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        @(negedge clk);
        beats_sent++;
        // Track what is sounding so that note-off beats can target live voices.
        if (int'(c.voice) < pool_now)
        begin
            if (c.mode == MODE_ACTIVATE)
            begin
                sounding[c.voice] = int'(c.note);
            end
            else if (c.mode == MODE_DEACTIVATE)
            begin
                sounding[c.voice] = -1;
            end
        end
    endtask

    // Asks the block for a voice and waits for its answer, as a synth would
    // before it starts the note.
    task automatic pick_voice(output int v);
        issue(beat_of(MODE_CHOOSE, $urandom_range(15), $urandom_range(128), $urandom));
        start <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (done)
            begin
                break;
            end
        end
        v = int'(result.chosen_voice[3:0]);
        @(negedge clk);
    endtask

    // Holds the sender off until every expected result has come, then lets the
    // block settle for a full result latency.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register writes happen only with the block idle: setup cycle, then access.
    task automatic set_voices(int value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= VOICE_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
            begin
                break;
            end
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Out-of-range counts act as the nearest legal one.
        pool_now = value & 5'h1f;
        if (pool_now == 0)
        begin
            pool_now = 1;
        end
        else if (pool_now > MAX_VOICES)
        begin
            pool_now = MAX_VOICES;
        end
        settings_used++;
    endtask

    // Note-on: choose, sometimes release a stolen voice first, then activate.
    task automatic note_on();
        int v;
        int pitch;
        pick_voice(v);
        if (v < pool_now && sounding[v] >= 0 && $urandom_range(3) == 0)
        begin
            issue(beat_of(MODE_DEACTIVATE, v, sounding[v], clock_ms));
        end
        pitch    = ($urandom_range(15) == 0) ? 128 : $urandom_range(127);
        clock_ms = clock_ms + $urandom_range(3);
        issue(beat_of(MODE_ACTIVATE, v, pitch, clock_ms));
    endtask

    // Note-off: release a sounding voice (a silent one if none sounds) with its own
    // note, now and then with some other note so that stale map entries are exercised.
    task automatic note_off();
        int v;
        int first;
        int pitch;
        first = $urandom_range(pool_now - 1);
        v     = -1;
        for (int k = 0; k < pool_now; k++)
        begin
            if (v < 0 && sounding[(first + k) % pool_now] >= 0)
            begin
                v = (first + k) % pool_now;
            end
        end
        if (v < 0)
        begin
            v = first;
        end
        if ($urandom_range(9) == 0 || sounding[v] < 0)
        begin
            pitch = $urandom_range(128);
        end
        else
        begin
            pitch = sounding[v];
        end
        clock_ms = clock_ms + $urandom_range(2);
        issue(beat_of(MODE_DEACTIVATE, v, pitch, clock_ms));
    endtask

    // Mostly well-formed note traffic, with queries and fully random beats mixed in.
    task automatic run_random(int count);
        int stop;
        int roll;
        stop = beats_sent + count;
        while (beats_sent < stop)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
            begin
                note_on();
            end
            else if (roll < 70)
            begin
                note_off();
            end
            else if (roll < 80)
            begin
                issue(beat_of(MODE_QUERY, $urandom_range(15), $urandom_range(128), $urandom));
            end
            else
            begin
                issue(beat_of(2'($urandom), $urandom_range(15),
                              ($urandom_range(7) == 0) ? $urandom_range(255)
                                                       : $urandom_range(128),
                              ($urandom_range(3) == 0) ? clock_ms : $urandom));
            end
        end
    endtask

    // One phase: a voice-count setting and a sender idling rate, with a full
    // pause halfway through.
    task automatic run_phase(int voices, int idle);
        set_voices(voices);
        idle_pct = idle;
        run_random(HALF_PHASE_BEATS);
        drain();
        run_random(HALF_PHASE_BEATS);
    endtask

    initial
    begin
        // Every input has a known value from time zero.
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        beats_sent    = 0;
        settings_used = 0;
        pool_now      = MAX_VOICES;
        clock_ms      = 32'd1000;
        for (int v = 0; v < MAX_VOICES; v++)
        begin
            sounding[v] = -1;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, full pool. An empty pool answers a query, then the
        // first choice wraps round to voice 0.
        issue(beat_of(MODE_QUERY, 0, 0, 32'd0));
        issue(beat_of(MODE_CHOOSE, 0, 0, 32'd0));
        // Start time all ones, the extreme voices and notes, no-note and
        // out-of-range notes.
        issue(beat_of(MODE_ACTIVATE, 0, 0, 32'hffff_ffff));
        issue(beat_of(MODE_ACTIVATE, 15, 127, 32'd0));
        issue(beat_of(MODE_ACTIVATE, 1, 128, 32'd5));
        issue(beat_of(MODE_ACTIVATE, 2, 255, 32'd7));
        // Activating a busy voice leaves the old note's map entry behind.
        issue(beat_of(MODE_ACTIVATE, 0, 60, 32'd100));
        issue(beat_of(MODE_QUERY, 0, 0, 32'd0));
        // Releasing a silent voice still counts down; release clears the map
        // entry of the note given, not of the note stored.
        issue(beat_of(MODE_DEACTIVATE, 3, 64, 32'd0));
        issue(beat_of(MODE_DEACTIVATE, 1, 127, 32'd0));
        issue(beat_of(MODE_QUERY, 15, 127, 32'd0));
        issue(beat_of(MODE_CHOOSE, 0, 60, 32'd0));

        // Two voices: the count saturates, steals take the lowest index on a
        // tie, and voices beyond the count are ignored.
        set_voices(2);
        issue(beat_of(MODE_ACTIVATE, 0, 10, 32'd50));
        issue(beat_of(MODE_ACTIVATE, 1, 11, 32'd50));
        issue(beat_of(MODE_CHOOSE, 0, 10, 32'd0));
        issue(beat_of(MODE_ACTIVATE, 1, 12, 32'hffff_ffff));
        issue(beat_of(MODE_CHOOSE, 1, 12, 32'd0));
        issue(beat_of(MODE_ACTIVATE, 5, 20, 32'd9));
        issue(beat_of(MODE_DEACTIVATE, 9, 11, 32'd0));
        issue(beat_of(MODE_QUERY, 9, 10, 32'd0));

        // A count of zero acts as one voice, which is busy, so it is stolen.
        set_voices(0);
        issue(beat_of(MODE_CHOOSE, 0, 0, 32'd0));

        // A count above the pool acts as the full pool; release until the
        // active count sticks at zero.
        set_voices(31);
        repeat (4) issue(beat_of(MODE_DEACTIVATE, 4, 128, 32'd0));

        // Random phases across voice counts and sender idling rates.
        run_phase(16, 0);
        run_phase(5, 86);
        run_phase(1, 19);
        run_phase(17, 0);
        run_phase(0, 86);
        run_phase($urandom_range(1, 16), 19);

        drain();
        $display("Covered %0d command beats over %0d voice-count settings.",
                 beats_sent, settings_used + 1);
        $display("Checked %0d result beats, %0d of them voice steals.", beats_checked, steals);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[polyphonic_voice_allocator] OK");
        end
        else
        begin
            $display("[polyphonic_voice_allocator] ERROR");
        end
        $finish;
    end

endmodule

// ===== polyphonic_voice_allocator.f =====
rtl/core/pva_pkg.sv
rtl/core/pva_voice_cell.sv
rtl/core/pva_note_map.sv
rtl/core/polyphonic_voice_allocator.sv
tb/pva_checker.sv
tb/tb.sv
